FILE: design/art_pkg.sv
`default_nettype none
package art_pkg;

    localparam int SAMPLE_BITS       = 12;
    localparam int SAMPLES_PER_GROUP = 4;
    localparam int GROUP_CNT_BITS    = $clog2(SAMPLES_PER_GROUP);
    localparam int SUM_BITS          = SAMPLE_BITS + GROUP_CNT_BITS;
    localparam int ACC_BITS          = 32;
    localparam int ROOT_BITS         = ACC_BITS / 2;
    localparam int DEV_BITS          = ROOT_BITS + 1;
    localparam int SQ_SHIFT          = 4;
    localparam int VAR_BITS          = ACC_BITS - SQ_SHIFT;

    localparam logic [ACC_BITS-1:0] MEAN_RESET = 32'd536870912;
    localparam logic [VAR_BITS-1:0] VAR_CLAMP  = 28'd4000000;

    localparam int MEAN_IN_SHIFT    = 8;
    localparam int MEAN_DECAY_SHIFT = 8;
    localparam int MEAN_UNITS_SHIFT = 16;
    localparam int MEAN_LEVEL_SHIFT = 18;
    localparam int VAR_IN_SHIFT     = 2;
    localparam int VAR_DECAY_SHIFT  = 6;

    localparam logic [ACC_BITS-1:0] ROOT_FIRST_BIT = 32'h4000_0000;

    typedef struct packed {
        logic take;
        logic mean_step;
        logic square_step;
        logic var_step;
        logic root_step;
        logic out_load;
    } art_cmd_t;

    typedef struct packed {
        logic group_last;
        logic root_last;
        logic out_free;
    } art_status_t;

endpackage
`default_nettype wire

FILE: design/art_if.sv
`default_nettype none
interface art_sample_if;
    import art_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface art_result_if;
    import art_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] mean_level;
    logic [ROOT_BITS-1:0]   stdev_x16;

    modport source (output valid, output mean_level, output stdev_x16, input ready);
    modport sink   (input valid, input mean_level, input stdev_x16, output ready);
endinterface
`default_nettype wire

FILE: design/art_datapath.sv
`default_nettype none
module art_datapath
    import art_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire art_cmd_t               cmd,
    output art_status_t                 status,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output logic [SAMPLE_BITS-1:0]      mean_level,
    output logic [ROOT_BITS-1:0]        stdev_x16
);

    logic [GROUP_CNT_BITS-1:0] cnt_reg;
    logic [SUM_BITS-1:0]       group_sum_reg;
    logic [SUM_BITS-1:0]       sum_reg;
    logic [ACC_BITS-1:0]       mean_reg;
    logic [ACC_BITS-1:0]       var_reg;
    logic [ACC_BITS-1:0]       sq_reg;
    logic [ACC_BITS-1:0]       rem_reg;
    logic [ACC_BITS-1:0]       root_reg;
    logic [ACC_BITS-1:0]       bit_reg;
    logic                      out_valid_reg;
    logic [SAMPLE_BITS-1:0]    mean_level_reg;
    logic [ROOT_BITS-1:0]      stdev_reg;

    logic [SUM_BITS-1:0] sum_next;
    logic [ACC_BITS-1:0] mean_next;
    logic [DEV_BITS-1:0] dev;
    logic [ROOT_BITS-1:0] dev_mag;
    logic [VAR_BITS-1:0] v_raw;
    logic [VAR_BITS-1:0] v_clamped;
    logic [ACC_BITS-1:0] var_next;
    logic [ACC_BITS-1:0] trial;

    assign sum_next  = group_sum_reg + SUM_BITS'(sample);
    assign mean_next = mean_reg + (ACC_BITS'(sum_reg) << MEAN_IN_SHIFT)
                       - (mean_reg >> MEAN_DECAY_SHIFT);

    // deviation of the group sum from the mean, both in group-sum units
    assign dev     = DEV_BITS'(sum_reg) - DEV_BITS'(mean_reg[ACC_BITS-1:MEAN_UNITS_SHIFT]);
    assign dev_mag = dev[DEV_BITS-1] ? ROOT_BITS'(-dev) : dev[ROOT_BITS-1:0];

    assign v_raw     = sq_reg[ACC_BITS-1:SQ_SHIFT];
    assign v_clamped = (v_raw > VAR_CLAMP) ? VAR_CLAMP : v_raw;
    assign var_next  = var_reg + (ACC_BITS'(v_clamped) << VAR_IN_SHIFT)
                       - (var_reg >> VAR_DECAY_SHIFT);

    assign trial = root_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            group_sum_reg <= '0;
            mean_reg      <= MEAN_RESET;
            var_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                if (status.group_last)
                begin
                    cnt_reg       <= '0;
                    group_sum_reg <= '0;
                end
                else
                begin
                    cnt_reg       <= cnt_reg + 1'b1;
                    group_sum_reg <= sum_next;
                end
            end
            if (cmd.mean_step)
            begin
                mean_reg <= mean_next;
            end
            if (cmd.var_step)
            begin
                var_reg <= var_next;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && status.group_last)
        begin
            sum_reg <= sum_next;
        end
        if (cmd.square_step)
        begin
            sq_reg <= ACC_BITS'(dev_mag * dev_mag);
        end
        if (cmd.var_step)
        begin
            rem_reg  <= var_next;
            root_reg <= '0;
            bit_reg  <= ROOT_FIRST_BIT;
        end
        else if (cmd.root_step)
        begin
            // one result bit per beat of the shift-subtract root
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.out_load)
        begin
            mean_level_reg <= mean_reg[MEAN_LEVEL_SHIFT +: SAMPLE_BITS];
            stdev_reg      <= root_reg[ROOT_BITS-1:0];
        end
    end

    assign status.group_last = (cnt_reg == GROUP_CNT_BITS'(SAMPLES_PER_GROUP - 1));
    assign status.root_last  = bit_reg[0];
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign mean_level = mean_level_reg;
    assign stdev_x16  = stdev_reg;

endmodule
`default_nettype wire

FILE: design/art_ctrl.sv
`default_nettype none
module art_ctrl
    import art_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire art_status_t status,
    output art_cmd_t         cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MEAN   = 6'b000010,
        S_SQUARE = 6'b000100,
        S_VAR    = 6'b001000,
        S_ROOT   = 6'b010000,
        S_OUT    = 6'b100000
    } art_state_t;

    art_state_t state_reg;
    art_state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.take        = in_ready && in_valid;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.take && status.group_last)
                begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                cmd.mean_step = 1'b1;
                state_next    = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.square_step = 1'b1;
                state_next      = S_VAR;
            end
            S_VAR:
            begin
                cmd.var_step = 1'b1;
                state_next   = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the result register can take the beat
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/ac_level_rms_tracker.sv
// AC level tracker: takes 12-bit unsigned samples and, after every fourth sample, gives one
// result beat holding the running mean in sample units and the running standard deviation
// times 16. Samples within a group are taken one per cycle. The fourth sample of a group
// starts an update that holds off further samples while it steps through the mean, the
// square of the deviation, the variance average, the bit-serial square root (one root bit
// per cycle) and the load of the result register. The update is held up only while a
// previous result still waits in the output register. After reset the mean starts at
// mid-scale and the variance at zero.
`default_nettype none
module ac_level_rms_tracker
    import art_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    art_sample_if.sink    samples,
    art_result_if.source  results
);

    art_cmd_t    cmd;
    art_status_t status;

    art_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    art_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .sample     (samples.sample),
        .out_ready  (results.ready),
        .out_valid  (results.valid),
        .mean_level (results.mean_level),
        .stdev_x16  (results.stdev_x16)
    );

endmodule
`default_nettype wire

FILE: design/art_checker.sv
`default_nettype none
module art_checker
    import art_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_ready,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic [SAMPLE_BITS-1:0] mean_level,
    input  wire logic [ROOT_BITS-1:0]   stdev_x16
);

    logic [GROUP_CNT_BITS-1:0] beat_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_cnt_reg <= '0;
        end
        else if (in_valid && in_ready)
        begin
            beat_cnt_reg <= beat_cnt_reg + 1'b1;
        end
    end

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mean_level) && $stable(stdev_x16))
        else $error("result changed while stalled");

    // the last beat of a group closes the input for the update
    a_group_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (beat_cnt_reg == GROUP_CNT_BITS'(SAMPLES_PER_GROUP - 1))
        |=> !in_ready)
        else $error("input open straight after a full group");

    // a fresh result only comes out of an update, during which input is closed
    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without an update");

    // variance average stays below 2^30, so the root stays below 2^15
    a_stdev_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !stdev_x16[ROOT_BITS-1])
        else $error("standard deviation out of range");

endmodule

bind ac_level_rms_tracker art_checker u_art_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .mean_level (results.mean_level),
    .stdev_x16  (results.stdev_x16)
);
`default_nettype wire
